### sv/pvh_pkg.sv
// ----------------------------------------------------------------------------
// pvh_pkg
// Shared types and fixed field widths of the point voxel histogram.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pvh_pkg;

  localparam int GRID_W    = 13;  // grid size registers and per-axis bin numbers
  localparam int THR_W     = 16;  // occupancy threshold register
  localparam int IDX_W     = 12;  // read_index and voxel_index fields
  localparam int CNT_OUT_W = 16;  // count field
  localparam int OP_W      = 2;   // operation field
  localparam int Q_CNT_W   = 4;   // divider step counter, holds GRID_W - 1

  typedef enum logic [OP_W-1:0] {
    OP_ADD   = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [2:0] {
    CFG_ORIGIN_X   = 3'd0,
    CFG_ORIGIN_Y   = 3'd1,
    CFG_ORIGIN_Z   = 3'd2,
    CFG_VOXEL_SIZE = 3'd3,
    CFG_GRID_X     = 3'd4,
    CFG_GRID_Y     = 3'd5,
    CFG_GRID_Z     = 3'd6,
    CFG_THRESHOLD  = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_e;

  // Divider status toward the sequencer.
  typedef struct packed {
    logic done;
    logic ovf;
  } div_stat_t;

  // Count store commands from the sequencer.
  typedef struct packed {
    logic rd;
    logic wr;
    logic clear;
  } mem_ctrl_t;

endpackage

### sv/point_voxel_histogram_top.sv
// ----------------------------------------------------------------------------
// point_voxel_histogram_top
// Add: each axis of an in-grid point passes the shared serial divider, then
//   index multiply-adds and a count update follow; a point is dropped early
//   when it misses the grid. Read: one store read. One item at a time: the next
//   item is taken once the result is issued and the store is not sweeping.
// Reset and clear: a sweep zeroes all MAX_VOXELS counts, not ready meanwhile.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_voxel_histogram_top #(
  parameter int MAX_VOXELS = 4096,
  parameter int COUNT_BITS = 16,
  parameter int COORD_BITS = 24
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    cfg_we_i,
  input  pvh_pkg::cfg_idx_e                       cfg_idx_i,
  input  logic [((COORD_BITS > 16) ? COORD_BITS : 16)-1:0] cfg_wdata_i,
  input  logic                                    in_valid_i,
  output logic                                    in_ready_o,
  input  logic [pvh_pkg::OP_W-1:0]                operation_i,
  input  logic signed [COORD_BITS-1:0]            point_x_i,
  input  logic signed [COORD_BITS-1:0]            point_y_i,
  input  logic signed [COORD_BITS-1:0]            point_z_i,
  input  logic [pvh_pkg::IDX_W-1:0]               read_index_i,
  output logic                                    out_valid_o,
  input  logic                                    out_ready_i,
  output logic [pvh_pkg::IDX_W-1:0]               voxel_index_o,
  output logic                                    in_grid_o,
  output logic [pvh_pkg::CNT_OUT_W-1:0]           count_o,
  output logic                                    occupied_o
);
  import pvh_pkg::*;

  localparam int DW    = COORD_BITS;
  localparam int AW    = $clog2(MAX_VOXELS);
  localparam int MW    = 2 * GRID_W;
  localparam int LIN_W = MW + GRID_W;
  localparam int CMP_W = (COUNT_BITS > THR_W) ? COUNT_BITS : THR_W;

  typedef enum logic [7:0] {
    S_IDLE = 8'b0000_0001,
    S_PREP = 8'b0000_0010,
    S_DIV  = 8'b0000_0100,
    S_LIN1 = 8'b0000_1000,
    S_LIN2 = 8'b0001_0000,
    S_RD   = 8'b0010_0000,
    S_UPD  = 8'b0100_0000,
    S_DONE = 8'b1000_0000
  } state_e;

  // Configuration registers
  logic [DW-1:0]     org_x_q, org_y_q, org_z_q;
  logic [DW-2:0]     vsize_q;
  logic [GRID_W-1:0] grid_x_q, grid_y_q, grid_z_q;
  logic [THR_W-1:0]  thr_q;

  // Sequencer and item registers
  state_e            state_q, state_d;
  axis_e             axis_q, axis_d;
  logic              op_add_q, op_add_d;
  logic [DW-1:0]     px_q, py_q, pz_q;
  logic [GRID_W-1:0] qx_q, qy_q, qz_q;
  logic [LIN_W-1:0]  lin_q;

  logic              res_ld;
  logic [IDX_W-1:0]  res_idx_d, res_idx_q;
  logic              res_in_d, res_in_q;
  logic [CNT_OUT_W-1:0] res_cnt_d, res_cnt_q;
  logic              res_occ_d, res_occ_q;

  logic              out_valid_q, out_valid_d;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_in_q;
  logic [CNT_OUT_W-1:0] out_cnt_q;
  logic              out_occ_q;

  logic              accept;
  logic              out_free;

  // Axis datapath
  logic [DW-1:0]     p_sel, o_sel;
  logic [GRID_W-1:0] n_sel;
  logic [DW:0]       delta;
  logic              delta_neg;

  // Shared multiply-add for the linear index
  logic [MW-1:0]     mac_a;
  logic [GRID_W-1:0] mac_b, mac_c;
  logic [LIN_W-1:0]  mac_y;

  logic              div_start;
  div_stat_t         div_stat;
  logic [GRID_W-1:0] div_quot;

  mem_ctrl_t         mem_ctrl;
  logic [COUNT_BITS-1:0] mem_rdata, cnt_new;
  logic              mem_busy;
  logic              lin_in_store;

  assign accept   = in_valid_i & in_ready_o;
  assign out_free = ~out_valid_q | out_ready_i;

  // --------------------------------------------------------------------------
  // Configuration
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      org_x_q  <= '0;
      org_y_q  <= '0;
      org_z_q  <= '0;
      vsize_q  <= (DW-1)'(256);
      grid_x_q <= GRID_W'(16);
      grid_y_q <= GRID_W'(16);
      grid_z_q <= GRID_W'(16);
      thr_q    <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_ORIGIN_X:   org_x_q  <= cfg_wdata_i[DW-1:0];
        CFG_ORIGIN_Y:   org_y_q  <= cfg_wdata_i[DW-1:0];
        CFG_ORIGIN_Z:   org_z_q  <= cfg_wdata_i[DW-1:0];
        CFG_VOXEL_SIZE: vsize_q  <= cfg_wdata_i[DW-2:0];
        CFG_GRID_X:     grid_x_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_GRID_Y:     grid_y_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_GRID_Z:     grid_z_q <= cfg_wdata_i[GRID_W-1:0];
        CFG_THRESHOLD:  thr_q    <= cfg_wdata_i[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Datapath
  // --------------------------------------------------------------------------
  always_comb begin
    case (axis_q)
      AXIS_X: begin
        p_sel = px_q;
        o_sel = org_x_q;
        n_sel = grid_x_q;
      end
      AXIS_Y: begin
        p_sel = py_q;
        o_sel = org_y_q;
        n_sel = grid_y_q;
      end
      default: begin
        p_sel = pz_q;
        o_sel = org_z_q;
        n_sel = grid_z_q;
      end
    endcase
  end

  assign delta     = {p_sel[DW-1], p_sel} - {o_sel[DW-1], o_sel};
  assign delta_neg = delta[DW];
  assign div_start = (state_q == S_PREP) && !delta_neg && (vsize_q != '0);

  // First pass forms qz*grid_y + qy, the second multiplies that by grid_x and adds qx.
  assign mac_a = (state_q == S_LIN1) ? MW'(qz_q) : lin_q[MW-1:0];
  assign mac_b = (state_q == S_LIN1) ? grid_y_q : grid_x_q;
  assign mac_c = (state_q == S_LIN1) ? qy_q : qx_q;
  assign mac_y = LIN_W'(mac_a) * LIN_W'(mac_b) + LIN_W'(mac_c);

  assign lin_in_store = lin_q < LIN_W'(MAX_VOXELS);
  assign cnt_new      = (op_add_q && (mem_rdata != '1)) ? mem_rdata + 1'b1 : mem_rdata;

  pvh_div #(
    .DW (DW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (delta[DW-1:0]),
    .divisor_i  (vsize_q),
    .stat_o     (div_stat),
    .quot_o     (div_quot)
  );

  assign mem_ctrl.rd    = (state_q == S_RD) && lin_in_store;
  assign mem_ctrl.wr    = (state_q == S_UPD) && op_add_q;
  assign mem_ctrl.clear = accept && (op_e'(operation_i) == OP_CLEAR);

  pvh_store #(
    .DEPTH (MAX_VOXELS),
    .AW    (AW),
    .DW    (COUNT_BITS)
  ) u_store (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .addr_i  (lin_q[AW-1:0]),
    .wdata_i (cnt_new),
    .rdata_o (mem_rdata),
    .busy_o  (mem_busy)
  );

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  assign in_ready_o = (state_q == S_IDLE) && !mem_busy;

  always_comb begin
    state_d   = state_q;
    axis_d    = axis_q;
    op_add_d  = op_add_q;
    res_ld    = 1'b0;
    res_idx_d = '0;
    res_in_d  = 1'b0;
    res_cnt_d = '0;
    res_occ_d = 1'b0;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (op_e'(operation_i))
            OP_ADD: begin
              op_add_d = 1'b1;
              axis_d   = AXIS_X;
              state_d  = S_PREP;
            end
            OP_READ: begin
              op_add_d = 1'b0;
              state_d  = S_RD;
            end
            default: begin
              // Clear and the unused code report an all-zero item.
              res_ld  = 1'b1;
              state_d = S_DONE;
            end
          endcase
        end
      end
      S_PREP: begin
        if (!div_start) begin
          res_ld  = 1'b1;
          state_d = S_DONE;
        end else begin
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        if (div_stat.done) begin
          if (div_stat.ovf || (div_quot >= n_sel)) begin
            res_ld  = 1'b1;
            state_d = S_DONE;
          end else if (axis_q == AXIS_Z) begin
            state_d = S_LIN1;
          end else begin
            axis_d  = (axis_q == AXIS_X) ? AXIS_Y : AXIS_Z;
            state_d = S_PREP;
          end
        end
      end
      S_LIN1: state_d = S_LIN2;
      S_LIN2: state_d = S_RD;
      S_RD: begin
        if (!lin_in_store) begin
          // A dropped point reports zeros; a read past the store reports its
          // index with a zero count.
          res_ld    = 1'b1;
          res_idx_d = op_add_q ? '0 : lin_q[IDX_W-1:0];
          state_d   = S_DONE;
        end else begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        res_ld    = 1'b1;
        res_idx_d = lin_q[IDX_W-1:0];
        res_in_d  = op_add_q;
        res_cnt_d = CNT_OUT_W'(cnt_new);
        res_occ_d = CMP_W'(cnt_new) > CMP_W'(thr_q);
        state_d   = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign out_valid_d = ((state_q == S_DONE) && out_free) ? 1'b1 :
                       (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      axis_q      <= AXIS_X;
      op_add_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      op_add_q    <= op_add_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      px_q <= point_x_i;
      py_q <= point_y_i;
      pz_q <= point_z_i;
    end
    if (accept && (op_e'(operation_i) == OP_READ)) begin
      lin_q <= LIN_W'(read_index_i);
    end else if ((state_q == S_LIN1) || (state_q == S_LIN2)) begin
      lin_q <= mac_y;
    end
    if ((state_q == S_DIV) && div_stat.done) begin
      case (axis_q)
        AXIS_X:  qx_q <= div_quot;
        AXIS_Y:  qy_q <= div_quot;
        default: qz_q <= div_quot;
      endcase
    end
    if (res_ld) begin
      res_idx_q <= res_idx_d;
      res_in_q  <= res_in_d;
      res_cnt_q <= res_cnt_d;
      res_occ_q <= res_occ_d;
    end
    if ((state_q == S_DONE) && out_free) begin
      out_idx_q <= res_idx_q;
      out_in_q  <= res_in_q;
      out_cnt_q <= res_cnt_q;
      out_occ_q <= res_occ_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign voxel_index_o = out_idx_q;
  assign in_grid_o     = out_in_q;
  assign count_o       = out_cnt_q;
  assign occupied_o    = out_occ_q;

endmodule

### sv/pvh_div.sv
// ----------------------------------------------------------------------------
// pvh_div
// Restoring divider producing a GRID_W-bit quotient, one bit per cycle, with
// an up-front overflow check for quotients that do not fit.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvh_div #(
  parameter int DW = 24
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [DW-1:0]           dividend_i,
  input  logic [DW-2:0]           divisor_i,
  output pvh_pkg::div_stat_t      stat_o,
  output logic [pvh_pkg::GRID_W-1:0] quot_o
);
  import pvh_pkg::*;

  localparam int ACC_W = DW + GRID_W;

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_CHECK = 3'b010,
    D_SHIFT = 3'b100
  } dstate_e;

  dstate_e              state_q, state_d;
  logic [ACC_W-1:0]     acc_q;
  logic [DW-2:0]        dvs_q;
  logic [Q_CNT_W-1:0]   cnt_q, cnt_d;
  logic                 done_q, done_d;
  logic                 ovf_q, ovf_d;

  logic [DW-1:0]        hi;
  logic [GRID_W-1:0]    lo;
  logic [DW-1:0]        opa;
  logic [DW:0]          diff;
  logic                 ge;

  assign hi = acc_q[ACC_W-1:GRID_W];
  assign lo = acc_q[GRID_W-1:0];

  // The check step compares the top part against the divisor unshifted: if it
  // is not smaller, the quotient needs more than GRID_W bits.
  assign opa  = (state_q == D_CHECK) ? hi : {hi[DW-2:0], lo[GRID_W-1]};
  assign diff = {1'b0, opa} - {2'b00, dvs_q};
  assign ge   = ~diff[DW];

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = 1'b0;
    ovf_d   = ovf_q;
    case (state_q)
      D_IDLE: begin
        if (start_i) begin
          state_d = D_CHECK;
          ovf_d   = 1'b0;
        end
      end
      D_CHECK: begin
        if (ge) begin
          done_d  = 1'b1;
          ovf_d   = 1'b1;
          state_d = D_IDLE;
        end else begin
          cnt_d   = Q_CNT_W'(GRID_W - 1);
          state_d = D_SHIFT;
        end
      end
      D_SHIFT: begin
        if (cnt_q == '0) begin
          done_d  = 1'b1;
          state_d = D_IDLE;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
      default: state_d = D_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= D_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      ovf_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      ovf_q   <= ovf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == D_IDLE && start_i) begin
      acc_q <= ACC_W'(dividend_i);
      dvs_q <= divisor_i;
    end else if (state_q == D_SHIFT) begin
      acc_q <= {(ge ? diff[DW-1:0] : opa), lo[GRID_W-2:0], ge};
    end
  end

  assign stat_o.done = done_q;
  assign stat_o.ovf  = ovf_q;
  assign quot_o      = lo;

endmodule

### sv/pvh_store.sv
// ----------------------------------------------------------------------------
// pvh_store
// Voxel count memory with one read and one write port and a clearing sweep
// that runs after reset and on request, one entry per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pvh_store #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pvh_pkg::mem_ctrl_t ctrl_i,
  input  logic [AW-1:0]      addr_i,
  input  logic [DW-1:0]      wdata_i,
  output logic [DW-1:0]      rdata_o,
  output logic               busy_o
);
  import pvh_pkg::*;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;
  logic [AW-1:0] clr_addr_q;
  logic          busy_q;

  logic          mem_we;
  logic [AW-1:0] mem_wa;
  logic [DW-1:0] mem_wd;

  assign mem_we = busy_q | ctrl_i.wr;
  assign mem_wa = busy_q ? clr_addr_q : addr_i;
  assign mem_wd = busy_q ? '0 : wdata_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (ctrl_i.clear) begin
      busy_q     <= 1'b1;
      clr_addr_q <= '0;
    end else if (busy_q) begin
      if (clr_addr_q == AW'(DEPTH - 1)) begin
        busy_q <= 1'b0;
      end else begin
        clr_addr_q <= clr_addr_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (ctrl_i.rd) begin
      rdata_q <= mem[addr_i];
    end
  end

  assign rdata_o = rdata_q;
  assign busy_o  = busy_q;

endmodule

### verif/point_voxel_histogram_top_test.sv
// ----------------------------------------------------------------------------
// point_voxel_histogram_top_test
// Self-checking bench for the voxel occupancy histogram. A directed table of
// items runs first, followed by aimed random points, reads, clears and noise
// under several grid settings. Each result is checked against its table row
// or a local binning and counting model, with random idling on both channels.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module point_voxel_histogram_top_test;

  import pvh_pkg::*;

  localparam int COORD_W  = 24;
  localparam int CFG_W    = 24;
  localparam int NVOX     = 4096;
  localparam int CNT_MAX  = 65535;
  localparam int SETTLE_CYCLES = 60;
  localparam int HOLD_CYCLES   = 500;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic [COORD_W-1:0] px;
    logic [COORD_W-1:0] py;
    logic [COORD_W-1:0] pz;
    logic [IDX_W-1:0]   ridx;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]     idx;
    logic                 ing;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 occ;
  } result_t;

  typedef struct packed {
    item_t   it;
    logic    typed;
    result_t want;
  } row_t;

  logic                 clk_i = 1'b0;
  logic                 rst_ni;
  logic                 cfg_we_i;
  cfg_idx_e             cfg_idx_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [OP_W-1:0]      operation_i;
  logic [COORD_W-1:0]   point_x_i;
  logic [COORD_W-1:0]   point_y_i;
  logic [COORD_W-1:0]   point_z_i;
  logic [IDX_W-1:0]     read_index_i;
  logic                 out_valid_o;
  logic                 out_ready_i = 1'b0;
  logic [IDX_W-1:0]     voxel_index_o;
  logic                 in_grid_o;
  logic [CNT_OUT_W-1:0] count_o;
  logic                 occupied_o;

  // Local copy of the grid setup and of the count store.
  logic [COORD_W-1:0] org_x, org_y, org_z;
  int unsigned        vox_edge, cells_x, cells_y, cells_z, occ_thr;
  int unsigned        voxel_tally [NVOX];
  logic [IDX_W-1:0]   recent_idx;

  result_t pending_results[$];
  row_t    directed_rows[$];
  int      mismatch_count = 0;
  int      send_idle_pct  = 0;
  int      recv_idle_pct  = 0;
  int      hold_asked     = 0;
  int      hold_granted   = 0;
  int      hold_left      = 0;

  point_voxel_histogram_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .operation_i   (operation_i),
    .point_x_i     (point_x_i),
    .point_y_i     (point_y_i),
    .point_z_i     (point_z_i),
    .read_index_i  (read_index_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .voxel_index_o (voxel_index_o),
    .in_grid_o     (in_grid_o),
    .count_o       (count_o),
    .occupied_o    (occupied_o)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #200_000_000;
    $display("point_voxel_histogram_top_test: errors");
    $finish;
  end

  // Floor division of one axis; returns 0 for a zero edge or off-grid point.
  function automatic bit axis_bin(logic [COORD_W-1:0] p, logic [COORD_W-1:0] o,
                                  int unsigned vs, int unsigned n, output longint q);
    longint d;
    longint b;
    d = longint'($signed(p)) - longint'($signed(o));
    q = 0;
    if (d < 0 || vs == 0) return 1'b0;
    b = d / longint'(vs);
    if (b >= longint'(n)) return 1'b0;
    q = b;
    return 1'b1;
  endfunction

  function automatic result_t bin_and_count(item_t it);
    result_t r;
    longint  qx, qy, qz, lin;
    int unsigned c;
    r = '0;
    case (it.op)
      OP_ADD: begin
        if (axis_bin(it.px, org_x, vox_edge, cells_x, qx) &&
            axis_bin(it.py, org_y, vox_edge, cells_y, qy) &&
            axis_bin(it.pz, org_z, vox_edge, cells_z, qz)) begin
          lin = qz * (longint'(cells_x) * longint'(cells_y)) + qy * longint'(cells_x) + qx;
          if (lin < NVOX) begin
            c = voxel_tally[lin];
            if (c < CNT_MAX) c++;
            voxel_tally[lin] = c;
            recent_idx = lin[IDX_W-1:0];
            r.idx = lin[IDX_W-1:0];
            r.ing = 1'b1;
            r.cnt = c[CNT_OUT_W-1:0];
            r.occ = (c > occ_thr);
          end
        end
      end
      OP_READ: begin
        c = voxel_tally[it.ridx];
        r.idx = it.ridx;
        r.cnt = c[CNT_OUT_W-1:0];
        r.occ = (c > occ_thr);
      end
      OP_CLEAR: begin
        foreach (voxel_tally[i]) voxel_tally[i] = 0;
      end
      default: ;
    endcase
    return r;
  endfunction

  // Coordinate that usually lands in a low bin, sometimes just off an edge.
  function automatic logic [COORD_W-1:0] aim_coord(logic [COORD_W-1:0] o,
                                                   int unsigned vs, int unsigned n);
    longint      q, off, v;
    int unsigned pick;
    pick = $urandom_range(99);
    if (n == 0) q = 0;
    else q = longint'($urandom_range((n > 4) ? 3 : n - 1));
    if (pick < 6) q = longint'(n);
    if (vs == 0) off = 0;
    else if (pick % 3 == 0) off = 0;
    else if (pick % 3 == 1) off = longint'(vs) - 1;
    else off = longint'($urandom_range(vs - 1));
    v = longint'($signed(o)) + q * longint'(vs) + off;
    if (pick >= 6 && pick < 10) v = longint'($signed(o)) - 1;
    return v[COORD_W-1:0];
  endfunction

  function automatic item_t make_item();
    item_t       it;
    int unsigned r;
    r = $urandom_range(99);
    it.op   = OP_ADD;
    it.px   = COORD_W'($urandom);
    it.py   = COORD_W'($urandom);
    it.pz   = COORD_W'($urandom);
    it.ridx = IDX_W'($urandom);
    if (r < 72) begin
      it.px = aim_coord(org_x, vox_edge, cells_x);
      it.py = aim_coord(org_y, vox_edge, cells_y);
      it.pz = aim_coord(org_z, vox_edge, cells_z);
    end else if (r < 80) begin
      it.op = OP_ADD;
    end else if (r < 94) begin
      it.op = OP_READ;
      if ($urandom_range(1)) it.ridx = recent_idx;
    end else if (r < 97) begin
      it.op = OP_CLEAR;
    end else begin
      it.op = OP_UNUSED;
    end
    return it;
  endfunction

  function automatic row_t mk_row(logic [OP_W-1:0] op, int px, int py, int pz, int ridx,
                                  bit typed, int idx, bit ing, int cnt, bit occ);
    row_t row;
    row.it.op   = op;
    row.it.px   = px[COORD_W-1:0];
    row.it.py   = py[COORD_W-1:0];
    row.it.pz   = pz[COORD_W-1:0];
    row.it.ridx = ridx[IDX_W-1:0];
    row.typed   = typed;
    row.want.idx = idx[IDX_W-1:0];
    row.want.ing = ing;
    row.want.cnt = cnt[CNT_OUT_W-1:0];
    row.want.occ = occ;
    return row;
  endfunction

  task automatic add_row(row_t row);
    directed_rows = {directed_rows, row};
  endtask

  task automatic reg_write(cfg_idx_e idx, logic [CFG_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    case (idx)
      CFG_ORIGIN_X:   org_x    = val;
      CFG_ORIGIN_Y:   org_y    = val;
      CFG_ORIGIN_Z:   org_z    = val;
      CFG_VOXEL_SIZE: vox_edge = 32'(val[22:0]);
      CFG_GRID_X:     cells_x  = 32'(val[GRID_W-1:0]);
      CFG_GRID_Y:     cells_y  = 32'(val[GRID_W-1:0]);
      CFG_GRID_Z:     cells_z  = 32'(val[GRID_W-1:0]);
      CFG_THRESHOLD:  occ_thr  = 32'(val[THR_W-1:0]);
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_grid(int ox, int oy, int oz, int vs, int gx, int gy, int gz, int thr);
    reg_write(CFG_ORIGIN_X, ox[CFG_W-1:0]);
    reg_write(CFG_ORIGIN_Y, oy[CFG_W-1:0]);
    reg_write(CFG_ORIGIN_Z, oz[CFG_W-1:0]);
    reg_write(CFG_VOXEL_SIZE, vs[CFG_W-1:0]);
    reg_write(CFG_GRID_X, gx[CFG_W-1:0]);
    reg_write(CFG_GRID_Y, gy[CFG_W-1:0]);
    reg_write(CFG_GRID_Z, gz[CFG_W-1:0]);
    reg_write(CFG_THRESHOLD, thr[CFG_W-1:0]);
  endtask

  task automatic send_item(item_t it, bit typed, result_t want);
    result_t got;
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk_i);
      in_valid_i <= 1'b0;
    end
    @(negedge clk_i);
    in_valid_i   <= 1'b1;
    operation_i  <= it.op;
    point_x_i    <= it.px;
    point_y_i    <= it.py;
    point_z_i    <= it.pz;
    read_index_i <= it.ridx;
    do @(posedge clk_i); while (!in_ready_o);
    // The item was taken at this edge; the model always advances.
    got = bin_and_count(it);
    if (typed) got = want;
    pending_results = {pending_results, got};
  endtask

  // Stop offering items and wait until every result has come back.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic wait_idle();
    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    // A clear keeps sweeping the store after its result has gone out.
    while (!in_ready_o) @(posedge clk_i);
  endtask

  task automatic run_random(int n, int hold_at, int pause_at);
    for (int i = 0; i < n; i++) begin
      if (i == hold_at) hold_asked++;
      if (i == pause_at) settle();
      send_item(make_item(), 1'b0, '0);
    end
  endtask

  task automatic random_setup();
    int ox, oy, oz;
    ox = int'($urandom_range(8000)) - 4000;
    oy = int'($urandom_range(8000)) - 4000;
    oz = int'($urandom_range(8000)) - 4000;
    set_grid(ox, oy, oz, $urandom_range(2000, 1), $urandom_range(20, 1),
             $urandom_range(20, 1), $urandom_range(20, 1), $urandom_range(3));
  endtask

  // Receiver side: random stalls, plus one long hold-off when asked for.
  always @(negedge clk_i) begin
    if (hold_granted != hold_asked) begin
      hold_granted = hold_asked;
      hold_left    = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : check_results
    result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("%0t unexpected result idx=%0d in_grid=%0b count=%0d occ=%0b",
                   $realtime, voxel_index_o, in_grid_o, count_o, occupied_o);
      end else begin
        want = pending_results.pop_front();
        if (voxel_index_o !== want.idx || in_grid_o !== want.ing ||
            count_o !== want.cnt || occupied_o !== want.occ) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("%0t mismatch: exp idx=%0d in_grid=%0b count=%0d occ=%0b,",
                     $realtime, want.idx, want.ing, want.cnt, want.occ);
            $display("  got idx=%0d in_grid=%0b count=%0d occ=%0b",
                     voxel_index_o, in_grid_o, count_o, occupied_o);
          end
        end
      end
    end
  end

  initial begin
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = CFG_ORIGIN_X;
    cfg_wdata_i  = '0;
    in_valid_i   = 1'b0;
    operation_i  = OP_ADD;
    point_x_i    = '0;
    point_y_i    = '0;
    point_z_i    = '0;
    read_index_i = '0;
    org_x = '0;
    org_y = '0;
    org_z = '0;
    vox_edge = 256;
    cells_x  = 16;
    cells_y  = 16;
    cells_z  = 16;
    occ_thr  = 0;
    recent_idx = '0;
    foreach (voxel_tally[i]) voxel_tally[i] = 0;

    // Reset grid: origin 0, edge 1.0, 16 voxels per axis, threshold 0.
    add_row(mk_row(OP_READ, 0, 0, 0, 0,          1, 0, 0, 0, 0));
    add_row(mk_row(OP_READ, 0, 0, 0, 4095,       1, 4095, 0, 0, 0));
    add_row(mk_row(OP_ADD, 0, 0, 0, 0,           1, 0, 1, 1, 1));
    add_row(mk_row(OP_ADD, 0, 0, 0, 0,           1, 0, 1, 2, 1));
    add_row(mk_row(OP_ADD, 255, 255, 255, 0,     1, 0, 1, 3, 1));
    add_row(mk_row(OP_ADD, 256, 0, 0, 0,         1, 1, 1, 1, 1));
    add_row(mk_row(OP_ADD, 4095, 4095, 4095, 0,  1, 4095, 1, 1, 1));
    add_row(mk_row(OP_ADD, 4095, 0, 4095, 0,     1, 3855, 1, 1, 1));
    add_row(mk_row(OP_ADD, 4096, 0, 0, 0,        1, 0, 0, 0, 0));
    add_row(mk_row(OP_ADD, -1, 0, 0, 0,          1, 0, 0, 0, 0));
    add_row(mk_row(OP_ADD, 8388607, 0, 0, 0,     1, 0, 0, 0, 0));
    add_row(mk_row(OP_ADD, 0, -8388608, 0, 0,    1, 0, 0, 0, 0));
    add_row(mk_row(OP_ADD, 0, 0, 8388607, 4095,  1, 0, 0, 0, 0));
    add_row(mk_row(OP_READ, 0, 0, 0, 0,          1, 0, 0, 3, 1));
    add_row(mk_row(OP_READ, 0, 0, 0, 1,          1, 1, 0, 1, 1));
    add_row(mk_row(OP_READ, 0, 0, 0, 4095,       1, 4095, 0, 1, 1));
    add_row(mk_row(OP_UNUSED, 8388607, -8388608, 1193046, 4095,
                   1, 0, 0, 0, 0));
    add_row(mk_row(OP_CLEAR, -1, -1, -1, 4095,   1, 0, 0, 0, 0));
    add_row(mk_row(OP_READ, 0, 0, 0, 0,          1, 0, 0, 0, 0));
    add_row(mk_row(OP_READ, 0, 0, 0, 4095,       1, 4095, 0, 0, 0));
    add_row(mk_row(OP_ADD, 1000, 2000, 3000, 0,  0, 0, 0, 0, 0));
    add_row(mk_row(OP_READ, 0, 0, 0, 2931,       0, 0, 0, 0, 0));

    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    wait_idle();

    send_idle_pct = 29;
    recv_idle_pct = 66;
    foreach (directed_rows[i])
      send_item(directed_rows[i].it, directed_rows[i].typed, directed_rows[i].want);
    run_random(110, 40, -1);

    wait_idle();
    set_grid(-8388608, -1000, 5000, 1, 4096, 1, 1, 65535);
    run_random(90, -1, -1);

    send_idle_pct = 66;
    recv_idle_pct = 29;
    wait_idle();
    set_grid(-8388608, -8388608, -8388608, 8388607, 2, 2, 2, 1);
    run_random(40, -1, -1);

    wait_idle();
    set_grid(8388607, 8388607, 8388607, 1, 8191, 8191, 8191, 0);
    run_random(20, -1, -1);

    // A zero voxel edge drops every point.
    wait_idle();
    set_grid(0, 0, 0, 0, 16, 16, 16, 0);
    run_random(20, -1, -1);

    // A zero-sized axis drops every point as well.
    wait_idle();
    set_grid(-2000, -2000, -2000, 300, 0, 10, 10, 0);
    run_random(20, -1, -1);

    wait_idle();
    random_setup();
    run_random(60, -1, 30);
    wait_idle();
    random_setup();
    run_random(60, -1, -1);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    wait_idle();
    set_grid(0, 0, 0, 256, 16, 16, 16, 2);
    run_random(150, -1, -1);

    settle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("point_voxel_histogram_top_test: clean");
    end else begin
      $display("point_voxel_histogram_top_test: errors");
    end
    $finish;
  end

endmodule

### sim.f
sv/pvh_pkg.sv
sv/pvh_div.sv
sv/pvh_store.sv
sv/point_voxel_histogram_top.sv
verif/point_voxel_histogram_top_test.sv
